>>> src/ddo_pkg.sv
// Shared types, constants and tables for the differential drive odometry block.
`default_nettype none
package ddo_pkg;

  localparam int FRAC_BITS = 16;

  localparam int ANG_W  = 32;
  localparam int CFG_W  = 16;
  localparam int HEAD_W = 20;
  localparam int DIFF_W = ANG_W + 1;
  localparam int PROD_W = DIFF_W + CFG_W + 1;
  localparam int TRV_W  = PROD_W - FRAC_BITS;
  localparam int NUM_W  = TRV_W + 1 + FRAC_BITS;
  localparam int DIV_W  = NUM_W + 1;
  localparam int DVS_W  = HEAD_W - 1;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int HSUM_W = DIV_W + 1;
  localparam int Z_W    = 34;
  localparam int MP_W   = TRV_W + Z_W;
  localparam int INC_W  = MP_W - 30;
  localparam int POS_W  = INC_W + 1;

  localparam int ROT_STEPS = 24;
  localparam int ROT_W     = 5;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam int TWO_PI_Q = int'(((TWO_PI_Q60 >> (59 - FRAC_BITS)) + 64'd1) >> 1);
  localparam int PI_Q     = int'(((PI_Q60 >> (59 - FRAC_BITS)) + 64'd1) >> 1);

  // 2 pi reduction: 12-bit digits, quotient digit by reciprocal multiply
  localparam int MOD_DIG  = 12;
  localparam int MOD_NDIG = (DIV_W + MOD_DIG - 1) / MOD_DIG;
  localparam int MOD_W    = MOD_NDIG * MOD_DIG;
  localparam int MOD_V_W  = DVS_W + MOD_DIG;
  localparam int MOD_SH   = 48;
  localparam int MOD_RC_W = 30;
  localparam int MCNT_W   = $clog2(2 * MOD_NDIG + 1);
  localparam logic [MOD_RC_W-1:0] MOD_RECIP =
    MOD_RC_W'((64'd1 << MOD_SH) / 64'(TWO_PI_Q));

  localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] ROT_GAIN    = 34'sh026DD3B6A;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_AXIS   = 1'b1;

  localparam logic [CFG_W-1:0] RADIUS_RST = 16'd1343;
  localparam logic [CFG_W-1:0] AXIS_RST   = 16'd3408;

  typedef struct packed {
    logic signed [ANG_W-1:0] left_angle;
    logic signed [ANG_W-1:0] right_angle;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0]       x_position;
    logic signed [31:0]       z_position;
    logic signed [HEAD_W-1:0] heading;
  } out_data_t;

  typedef struct packed {
    logic             load_in;
    logic             mul_left;
    logic             mul_right;
    logic             div_start;
    logic             mod_start;
    logic             dth_load;
    logic             rot_prep;
    logic             rot_step;
    logic [ROT_W-1:0] rot_idx;
    logic             mul_sin;
    logic             mul_cos;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mod_done;
  } stat_t;

  function automatic logic [31:0] atan_q30(input logic [ROT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/ddo_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module ddo_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ddo_pkg::DIV_W-1:0] dividend,
  input  wire logic [ddo_pkg::DVS_W-1:0] divisor,
  output logic      [ddo_pkg::DIV_W-1:0] quotient,
  output logic                           done
);
  import ddo_pkg::*;

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

>>> src/ddo_dpath.sv
// Odometry datapath: travel multiply, divider, sine/cosine rotation, pose update.
`default_nettype none
module ddo_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ddo_pkg::cmd_t             cmd,
  output ddo_pkg::stat_t                 stat,
  input  wire ddo_pkg::in_data_t         in_data,
  input  wire logic [ddo_pkg::CFG_W-1:0] wheel_rad,
  input  wire logic [ddo_pkg::CFG_W-1:0] axle_len,
  output ddo_pkg::out_data_t             pose
);
  import ddo_pkg::*;

  localparam logic signed [HSUM_W-1:0] TWO_PI_H = HSUM_W'(TWO_PI_Q);
  localparam logic signed [HSUM_W-1:0] PI_H     = HSUM_W'(PI_Q);
  localparam logic signed [HEAD_W:0]   TWO_PI_R = (HEAD_W + 1)'(TWO_PI_Q);
  localparam logic signed [HEAD_W:0]   PI_R     = (HEAD_W + 1)'(PI_Q);
  localparam logic signed [POS_W-1:0]  POS_MAX  = POS_W'(64'sh7FFFFFFF);
  localparam logic signed [POS_W-1:0]  POS_MIN  = -POS_W'(64'sh80000000);

  in_data_t                   in_r;
  logic signed [ANG_W-1:0]    last_left_r, last_right_r;
  logic signed [31:0]         pose_x_r, pose_z_r;
  logic signed [HEAD_W-1:0]   pose_h_r;
  logic signed [TRV_W-1:0]    dl_r, dr_r;
  logic                       neg_src_r;
  logic signed [DIV_W-1:0]    dth_r;
  logic signed [TRV_W-1:0]    step_r;
  logic signed [Z_W-1:0]      x_r, y_r, z_r;
  logic                       flip_r;
  logic signed [31:0]         new_x_r, new_z_r;
  logic [MOD_W-1:0]           mag_r;
  logic [DVS_W-1:0]           mrem_r;
  logic [MOD_V_W-1:0]         mv_r;
  logic [MOD_DIG-1:0]         mq_r;
  logic [MCNT_W-1:0]          mcnt_r;
  logic                       mod_done_r;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   tprod;
  logic signed [TRV_W-1:0]    trav;
  logic signed [TRV_W:0]      dldr;
  logic signed [NUM_W-1:0]    numer;
  logic signed [DIV_W-1:0]    ang;
  logic signed [DIV_W-1:0]    src;
  logic [DIV_W-1:0]           dvd;
  logic [DVS_W-1:0]           dvs;
  logic [DIV_W-1:0]           quo;
  logic                       div_done;
  logic [MOD_V_W-1:0]         mv;
  logic [MOD_SH+MOD_DIG-1:0]  mqp;
  logic [MOD_DIG-1:0]         mq;
  logic [MOD_V_W-1:0]         mt;
  logic [DVS_W-1:0]           mrem;
  logic signed [HEAD_W:0]     r0, r1;
  logic signed [Z_W-1:0]      z0, z1;
  logic                       flip0;
  logic signed [Z_W-1:0]      xs, ys, at;
  logic signed [Z_W-1:0]      sn, cs, mop;
  logic signed [MP_W-1:0]     mprod;
  logic signed [INC_W-1:0]    inc;
  logic signed [POS_W-1:0]    psum;
  logic signed [31:0]         psat;
  logic signed [HSUM_W-1:0]   hsum, hclip, hfold;

  ddo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .quotient  (quo),
    .done      (div_done)
  );

  assign stat.div_done = div_done;
  assign stat.mod_done = mod_done_r;

  always_comb begin
    diff  = cmd.mul_right ? (DIFF_W'(in_r.right_angle) - DIFF_W'(last_right_r))
                          : (DIFF_W'(in_r.left_angle) - DIFF_W'(last_left_r));
    tprod = PROD_W'(diff) * PROD_W'($signed({1'b0, wheel_rad}));
    trav  = TRV_W'((tprod + PROD_W'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

    dldr  = (TRV_W + 1)'(dl_r) - (TRV_W + 1)'(dr_r);
    numer = {dldr, {FRAC_BITS{1'b0}}};
    ang   = DIV_W'(pose_h_r) + (dth_r >>> 1);
    src   = cmd.mod_start ? ang : DIV_W'(numer);
    dvd   = src[DIV_W-1] ? DIV_W'(-src) : DIV_W'(src);
    if (axle_len == '0) begin
      dvs = DVS_W'(1);
    end else begin
      dvs = DVS_W'(axle_len);
    end

    // one digit of |angle| mod 2 pi; estimate is exact or one low
    mv   = {mrem_r, mag_r[MOD_W-1 -: MOD_DIG]};
    mqp  = (MOD_SH + MOD_DIG)'(mv) * (MOD_SH + MOD_DIG)'(MOD_RECIP);
    mq   = MOD_DIG'(mqp >> MOD_SH);
    mt   = mv_r - MOD_V_W'(mq_r) * MOD_V_W'(TWO_PI_Q);
    mrem = (mt >= MOD_V_W'(TWO_PI_Q)) ? DVS_W'(mt - MOD_V_W'(TWO_PI_Q)) : DVS_W'(mt);

    if (neg_src_r && mrem_r != '0) begin
      r0 = TWO_PI_R - (HEAD_W + 1)'($signed({1'b0, mrem_r}));
    end else begin
      r0 = (HEAD_W + 1)'($signed({1'b0, mrem_r}));
    end
    r1 = (r0 > PI_R) ? (r0 - TWO_PI_R) : r0;
    z0 = Z_W'(r1) <<< (30 - FRAC_BITS);
    if (z0 > HALF_PI_Q30) begin
      z1    = z0 - PI_Q30;
      flip0 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z1    = z0 + PI_Q30;
      flip0 = 1'b1;
    end else begin
      z1    = z0;
      flip0 = 1'b0;
    end

    xs = x_r >>> cmd.rot_idx;
    ys = y_r >>> cmd.rot_idx;
    at = Z_W'($signed({1'b0, atan_q30(cmd.rot_idx)}));

    sn    = flip_r ? -y_r : y_r;
    cs    = flip_r ? -x_r : x_r;
    mop   = cmd.mul_cos ? cs : sn;
    mprod = MP_W'(step_r) * MP_W'(mop);
    inc   = INC_W'((mprod + MP_W'(64'sd1 <<< 29)) >>> 30);
    psum  = POS_W'(cmd.mul_cos ? pose_z_r : pose_x_r) + POS_W'(inc);
    if (psum > POS_MAX) begin
      psat = 32'sh7FFFFFFF;
    end else if (psum < POS_MIN) begin
      psat = 32'sh80000000;
    end else begin
      psat = psum[31:0];
    end

    hsum = HSUM_W'(pose_h_r) + HSUM_W'(dth_r);
    if (hsum > TWO_PI_H) begin
      hclip = TWO_PI_H;
    end else if (hsum < -TWO_PI_H) begin
      hclip = -TWO_PI_H;
    end else begin
      hclip = hsum;
    end
    if (hclip > PI_H && hclip < TWO_PI_H) begin
      hfold = hclip - TWO_PI_H;
    end else if (hclip < -PI_H && hclip > -TWO_PI_H) begin
      hfold = hclip + TWO_PI_H;
    end else begin
      hfold = hclip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r  <= '0;
      last_right_r <= '0;
      pose_x_r     <= '0;
      pose_z_r     <= '0;
      pose_h_r     <= '0;
    end else if (cmd.commit) begin
      last_left_r  <= in_r.left_angle;
      last_right_r <= in_r.right_angle;
      pose_x_r     <= new_x_r;
      pose_z_r     <= new_z_r;
      pose_h_r     <= HEAD_W'(hfold);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r     <= '0;
      mod_done_r <= 1'b0;
    end else begin
      mod_done_r <= (mcnt_r == MCNT_W'(1));
      if (cmd.mod_start) begin
        mcnt_r <= MCNT_W'(2 * MOD_NDIG);
      end else if (mcnt_r != '0) begin
        mcnt_r <= mcnt_r - MCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.mul_left) begin
      dl_r <= trav;
    end
    if (cmd.mul_right) begin
      dr_r <= trav;
    end
    if (cmd.div_start || cmd.mod_start) begin
      neg_src_r <= src[DIV_W-1];
    end
    if (cmd.dth_load) begin
      dth_r  <= neg_src_r ? -$signed(quo) : $signed(quo);
      step_r <= TRV_W'(((TRV_W + 1)'(dl_r) + (TRV_W + 1)'(dr_r)) >>> 1);
    end
    if (cmd.mod_start) begin
      mag_r  <= MOD_W'(dvd);
      mrem_r <= '0;
    end else if (mcnt_r != '0) begin
      if (!mcnt_r[0]) begin
        mv_r  <= mv;
        mq_r  <= mq;
        mag_r <= mag_r << MOD_DIG;
      end else begin
        mrem_r <= mrem;
      end
    end
    if (cmd.rot_prep) begin
      x_r    <= ROT_GAIN;
      y_r    <= '0;
      z_r    <= z1;
      flip_r <= flip0;
    end else if (cmd.rot_step) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.mul_sin) begin
      new_x_r <= psat;
    end
    if (cmd.mul_cos) begin
      new_z_r <= psat;
    end
  end

  assign pose.x_position = pose_x_r;
  assign pose.z_position = pose_z_r;
  assign pose.heading    = pose_h_r;

endmodule
`default_nettype wire

>>> src/ddo_ctrl.sv
// Sequencer for one odometry update and the result handshake.
`default_nettype none
module ddo_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ddo_pkg::cmd_t       cmd,
  input  wire ddo_pkg::stat_t stat
);
  import ddo_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_MUL_L     = 13'b0000000000010,
    S_MUL_R     = 13'b0000000000100,
    S_DIVT_GO   = 13'b0000000001000,
    S_DIVT_WAIT = 13'b0000000010000,
    S_DTH       = 13'b0000000100000,
    S_MOD_GO    = 13'b0000001000000,
    S_MOD_WAIT  = 13'b0000010000000,
    S_PREP      = 13'b0000100000000,
    S_ROT       = 13'b0001000000000,
    S_MUL_S     = 13'b0010000000000,
    S_MUL_C     = 13'b0100000000000,
    S_DONE      = 13'b1000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [ROT_W-1:0] rot_cnt_r, rot_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_commit;

  always_comb begin
    state_nxt   = state_r;
    rot_cnt_nxt = rot_cnt_r;
    cmd         = '0;
    cmd.rot_idx = rot_cnt_r;
    can_commit  = !out_valid_r || !out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL_L;
        end
      end
      S_MUL_L: begin
        cmd.mul_left = 1'b1;
        state_nxt    = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_right = 1'b1;
        state_nxt     = S_DIVT_GO;
      end
      S_DIVT_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVT_WAIT;
      end
      S_DIVT_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_DTH;
        end
      end
      S_DTH: begin
        cmd.dth_load = 1'b1;
        state_nxt    = S_MOD_GO;
      end
      S_MOD_GO: begin
        cmd.mod_start = 1'b1;
        state_nxt     = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (stat.mod_done) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.rot_prep = 1'b1;
        rot_cnt_nxt  = '0;
        state_nxt    = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        rot_cnt_nxt  = rot_cnt_r + ROT_W'(1);
        if (rot_cnt_r == ROT_W'(ROT_STEPS - 1)) begin
          state_nxt = S_MUL_S;
        end
      end
      S_MUL_S: begin
        cmd.mul_sin = 1'b1;
        state_nxt   = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_cos = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rot_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> src/diff_drive_odometry_unit.sv
// Differential drive odometry: wheel angle pairs in, updated pose out.
//
// Input channel (in_valid/in_stall/in_data): one pair of cumulative left and
// right wheel angles per transaction, Q16.16 radians.
// Result channel (out_valid/out_stall/out_data): one pose per input
// transaction: x and z in Q16.16 meters (saturating), heading in signed Q4.16 rad.
// Configuration: APB-style port; wheel radius at 0x0, wheel spacing at 0x4.
// Write only while the block is idle.
// Each update runs two travel multiplies, the one-bit-per-cycle serial divider
// for the heading change, digit-wise reduction by 2 pi, the CORDIC rotation
// and the setup and pose-update states. One transaction is in flight at a time
// and in_stall drops the cycle after the pose is committed, so the block takes
// no new input before the last one is through.
// A finished pose stays on out_data while out_stall is high; the next input
// is taken and processed meanwhile, and its pose is committed once the
// pending one is taken.
// Reset clears the pose, the previous angles and both handshakes, and loads
// the default wheel radius and wheel spacing.
`default_nettype none
module diff_drive_odometry_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ddo_pkg::in_data_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ddo_pkg::out_data_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import ddo_pkg::*;

  logic [CFG_W-1:0] radius_r, radius_nxt;
  logic [CFG_W-1:0] axis_r, axis_nxt;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    radius_nxt = radius_r;
    axis_nxt   = axis_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_RADIUS: radius_nxt = cfg_pwdata[CFG_W-1:0];
        REG_AXIS:   axis_nxt   = cfg_pwdata[CFG_W-1:0];
        default:    radius_nxt = radius_r;
      endcase
    end
    unique case (cfg_paddr[2])
      REG_RADIUS: cfg_prdata = {16'b0, radius_r};
      REG_AXIS:   cfg_prdata = {16'b0, axis_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      axis_r   <= AXIS_RST;
    end else begin
      radius_r <= radius_nxt;
      axis_r   <= axis_nxt;
    end
  end

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ddo_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .wheel_rad (radius_r),
    .axle_len  (axis_r),
    .pose      (out_data)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the differential drive odometry unit.
`default_nettype none
module testbench;
  import ddo_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_data_t out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  diff_drive_odometry_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  localparam longint ARCTAN_Q30 [ROT_STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  in_data_t  angle_q[$];
  out_data_t pose_q[$];
  int        fail_cnt = 0;
  logic      in_took = 1'b0;
  int        in_gap = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;

  longint radius_m = 1343, axis_m = 3408;
  longint prev_left = 0, prev_right = 0, pose_x = 0, pose_z = 0, pose_head = 0;

  function automatic longint round_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scaled_inc(input longint trv, input longint frac);
    logic signed [79:0] a, b, p;
    a = trv;
    b = frac;
    p = a * b + (80'sd1 <<< 29);
    p = p >>> 30;
    return longint'(p);
  endfunction

  function automatic out_data_t next_pose(input in_data_t d);
    longint l, r, axis, dl, dr, dth, trv, ang, zr, cx, cy, xs, ys, hd;
    bit flip;
    out_data_t o;
    l = longint'(d.left_angle);
    r = longint'(d.right_angle);
    axis = (axis_m == 0) ? 1 : axis_m;
    dl = round_shr((l - prev_left) * radius_m, FRAC_BITS);
    dr = round_shr((r - prev_right) * radius_m, FRAC_BITS);
    dth = ((dl - dr) * (64'sd1 <<< FRAC_BITS)) / axis;
    trv = (dl + dr) >>> 1;
    ang = (pose_head + (dth >>> 1)) % longint'(TWO_PI_Q);
    if (ang < 0) ang += TWO_PI_Q;
    if (ang > PI_Q) ang -= TWO_PI_Q;
    zr = ang * (64'sd1 <<< (30 - FRAC_BITS));
    flip = 1'b0;
    if (zr > longint'(HALF_PI_Q30)) begin
      zr -= longint'(PI_Q30);
      flip = 1'b1;
    end else if (zr < -longint'(HALF_PI_Q30)) begin
      zr += longint'(PI_Q30);
      flip = 1'b1;
    end
    cx = longint'(ROT_GAIN);
    cy = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (zr >= 0) begin
        cx -= ys; cy += xs; zr -= ARCTAN_Q30[i];
      end else begin
        cx += ys; cy -= xs; zr += ARCTAN_Q30[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    pose_x = clamp32(pose_x + scaled_inc(trv, cy));
    pose_z = clamp32(pose_z + scaled_inc(trv, cx));
    hd = pose_head + dth;
    if (hd > TWO_PI_Q) hd = TWO_PI_Q;
    if (hd < -TWO_PI_Q) hd = -TWO_PI_Q;
    if (hd > PI_Q && hd < TWO_PI_Q) hd -= TWO_PI_Q;
    else if (hd < -PI_Q && hd > -TWO_PI_Q) hd += TWO_PI_Q;
    pose_head = hd;
    prev_left = l;
    prev_right = r;
    o.x_position = pose_x[31:0];
    o.z_position = pose_z[31:0];
    o.heading = pose_head[HEAD_W-1:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // input driver
  always @(negedge clk) begin
    logic v;
    v = in_valid;
    if (rst_n && !(in_valid && !in_took)) begin
      v = 1'b0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (angle_q.size() != 0) begin
        in_data <= angle_q.pop_front();
        v = 1'b1;
        in_gap <= pick_gap();
      end
    end
    in_valid <= v;
  end

  // result stall driver
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    out_data_t exp_pose;
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) pose_q.push_back(next_pose(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $error("pose transaction with no expectation");
        fail_cnt++;
      end else begin
        exp_pose = pose_q.pop_front();
        if (out_data.x_position !== exp_pose.x_position) begin
          $error("x_position exp %0d got %0d", exp_pose.x_position, out_data.x_position);
          fail_cnt++;
        end
        if (out_data.z_position !== exp_pose.z_position) begin
          $error("z_position exp %0d got %0d", exp_pose.z_position, out_data.z_position);
          fail_cnt++;
        end
        if (out_data.heading !== exp_pose.heading) begin
          $error("heading exp %0d got %0d", exp_pose.heading, out_data.heading);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_RADIUS) radius_m = val;
    else axis_m = val;
  endtask

  task automatic drain();
    do @(posedge clk); while (angle_q.size() != 0 || in_valid || pose_q.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_pair(input logic [31:0] l, input logic [31:0] r);
    in_data_t d;
    d.left_angle = l;
    d.right_angle = r;
    angle_q.push_back(d);
  endtask

  task automatic random_drive(input int n);
    logic [31:0] l, r;
    int k;
    l = prev_left[31:0];
    r = prev_right[31:0];
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(4, 24);
        l = l + ($urandom() >> (32 - k)) - (32'd1 << (k - 1));
        r = r + ($urandom() >> (32 - k)) - (32'd1 << (k - 1));
      end else begin
        l = $urandom();
        r = $urandom();
      end
      push_pair(l, r);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default geometry: straight, turns, extremes, wrapping readings
    push_pair(32'h0, 32'h0);
    push_pair(32'h0001_0000, 32'h0001_0000);
    push_pair(32'h0003_0000, 32'h0001_0000);
    push_pair(32'h0003_0000, 32'h0004_0000);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h7FFF_FFFF, 32'h8000_0000);
    push_pair(32'h8000_0000, 32'h7FFF_FFFF);
    push_pair(32'hFFFF_FFFF, 32'h0000_0001);
    push_pair(32'h0, 32'h0);
    drain();

    // max radius, min axis: heading and position saturation
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_AXIS, 16'd1);
    push_pair(32'h7FFF_FFFF, 32'h8000_0000);
    push_pair(32'h8000_0000, 32'h7FFF_FFFF);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h0001_0000, 32'h0);
    drain();

    // zero axis length, minimum radius
    write_reg(REG_AXIS, 16'd0);
    write_reg(REG_RADIUS, 16'd1);
    push_pair(32'h0002_0000, 32'h0);
    push_pair(32'h7FFF_FFFF, 32'h0);
    push_pair(32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    random_drive(60);
    drain();

    write_reg(REG_RADIUS, 16'd1343);
    write_reg(REG_AXIS, 16'hFFFF);
    quiet = 1'b1;
    random_drive(200);
    drain();

    quiet = 1'b0;
    write_reg(REG_RADIUS, 16'd3000);
    write_reg(REG_AXIS, 16'd3408);
    random_drive(250);
    drain();

    for (int p = 0; p < 3; p++) begin
      quiet = $urandom_range(0, 1);
      write_reg(REG_RADIUS, 16'($urandom()));
      write_reg(REG_AXIS, 16'($urandom()));
      random_drive(150);
      drain();
    end

    if (pose_q.size() != 0) begin
      $error("poses still expected at end: %0d", pose_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire
